>>> src/sfr_pkg.sv
// Shared types and constants for the stream find/replace block.
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int BYTE_W     = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 64;
   localparam int LEN_REG_W  = 4;
   // pattern and replacement registers hold this many bytes
   localparam int REG_BYTES  = CSR_DATA_W / BYTE_W;

   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_LEN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PATTERN_BYTES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_LEN   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REPLACE_BYTES = 2'd3;

   // what the back end does with one queued command
   typedef enum logic [2:0] {
      CMD_WIN  = 3'b001,   // emit the front bytes of a window snapshot
      CMD_REPL = 3'b010,   // emit the replacement string
      CMD_MARK = 3'b100    // emit an empty end marker
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic         done;   // last command of the content
   } cmd_ctrl_type;

endpackage

>>> src/sfr_if.sv
// Request and response channel interfaces.
`timescale 1ns / 1ps

interface sfr_req_if;
   logic                     valid;
   logic                     ready;
   logic [sfr_pkg::BYTE_W-1:0] data_byte;
   logic                     end_of_content;

   modport source (output valid, output data_byte, output end_of_content, input ready);
   modport sink   (input valid, input data_byte, input end_of_content, output ready);
endinterface

interface sfr_rsp_if;
   logic                     valid;
   logic                     ready;
   logic [sfr_pkg::BYTE_W-1:0] out_byte;
   logic                     byte_valid;
   logic                     run_last;
   logic                     content_done;

   modport source (output valid, output out_byte, output byte_valid, output run_last,
                   output content_done, input ready);
   modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                   input content_done, output ready);
endinterface

>>> src/sfr_front.sv
// Front end: takes requests, tracks the partial match and queues emit commands.
`timescale 1ns / 1ps

module sfr_front #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8,
   localparam int CW   = $clog2(PATTERN_MAX + 1),
   localparam int LENW = $clog2(((PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX) + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic [sfr_pkg::BYTE_W-1:0]             req_data_byte,
   input  logic                                   req_end_of_content,
   input  logic [CW-1:0]                          plen,
   input  logic [PATTERN_MAX*sfr_pkg::BYTE_W-1:0] pat_vec,
   input  logic [LENW-1:0]                        rlen,
   output logic                                   cmd_valid,
   input  logic                                   cmd_ready,
   output sfr_pkg::cmd_ctrl_type                  cmd_ctrl,
   output logic [LENW-1:0]                        cmd_len,
   output logic [PATTERN_MAX*sfr_pkg::BYTE_W-1:0] cmd_bytes,
   output logic                                   held_empty
);

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_SCAN = 2'b10
   } front_state_type;

   front_state_type               state_ff, state_in;
   logic [sfr_pkg::BYTE_W-1:0]    win_ff  [PATTERN_MAX];
   logic [sfr_pkg::BYTE_W-1:0]    win_in  [PATTERN_MAX];
   logic [sfr_pkg::BYTE_W-1:0]    snap_ff [PATTERN_MAX];
   logic [sfr_pkg::BYTE_W-1:0]    snap_in [PATTERN_MAX];
   logic [CW-1:0]                 cnt_ff, cnt_in;
   logic [CW-1:0]                 n_ff, n_in;
   logic [CW-1:0]                 k_ff, k_in;
   logic [CW-1:0]                 norig_ff, norig_in;
   logic                          eoc_ff, eoc_in;
   logic                          pass_ff, pass_in;

   logic                          pre;
   logic                          full;
   logic                          scan_done;
   logic                          need_push;
   logic                          finish;
   logic [CW-1:0]                 emit_cnt;

   // held window (first n bytes) is a pattern prefix
   always_comb begin
      pre = 1'b1;
      for (int i = 0; i < PATTERN_MAX; i++) begin
         if ((CW'(i) < n_ff) &&
             (win_ff[i] != pat_vec[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W])) begin
            pre = 1'b0;
         end
      end
   end

   assign full      = !pass_ff && (n_ff == plen) && pre;
   assign scan_done = pass_ff || pre;
   // dropped bytes, or everything on a flush or in pass-through
   assign emit_cnt  = (pass_ff || eoc_ff) ? norig_ff : k_ff;

   always_comb begin
      need_push      = 1'b0;
      cmd_ctrl.kind  = sfr_pkg::CMD_MARK;
      cmd_ctrl.done  = eoc_ff;
      cmd_len        = LENW'(1);
      if (full) begin
         if (rlen != '0) begin
            need_push     = 1'b1;
            cmd_ctrl.kind = sfr_pkg::CMD_REPL;
            cmd_len       = rlen;
         end else if (eoc_ff) begin
            need_push = 1'b1;
         end
      end else begin
         if (emit_cnt != '0) begin
            need_push     = 1'b1;
            cmd_ctrl.kind = sfr_pkg::CMD_WIN;
            cmd_len       = LENW'(emit_cnt);
         end else if (eoc_ff) begin
            need_push = 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < PATTERN_MAX; i++) begin
         cmd_bytes[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = snap_ff[i];
      end
   end

   assign cmd_valid  = (state_ff == F_SCAN) && scan_done && need_push;
   assign finish     = (state_ff == F_SCAN) && scan_done && (!need_push || cmd_ready);
   assign req_ready  = (state_ff == F_IDLE);
   assign held_empty = (cnt_ff == '0);

   always_comb begin
      state_in = state_ff;
      win_in   = win_ff;
      snap_in  = snap_ff;
      cnt_in   = cnt_ff;
      n_in     = n_ff;
      k_in     = k_ff;
      norig_in = norig_ff;
      eoc_in   = eoc_ff;
      pass_in  = pass_ff;
      case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               for (int i = 0; i < PATTERN_MAX; i++) begin
                  if (CW'(i) == cnt_ff) begin
                     win_in[i] = req_data_byte;
                  end
               end
               snap_in  = win_in;
               n_in     = cnt_ff + CW'(1);
               norig_in = cnt_ff + CW'(1);
               k_in     = '0;
               eoc_in   = req_end_of_content;
               pass_in  = (plen == '0);
               state_in = F_SCAN;
            end
         end
         F_SCAN: begin
            if (!scan_done) begin
               // mismatch: drop the front byte and try again
               for (int i = 0; i < PATTERN_MAX - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               n_in = n_ff - CW'(1);
               k_in = k_ff + CW'(1);
            end else if (finish) begin
               cnt_in   = (full || eoc_ff || pass_ff) ? '0 : n_ff;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      win_ff   <= win_in;
      snap_ff  <= snap_in;
      n_ff     <= n_in;
      k_ff     <= k_in;
      norig_ff <= norig_in;
      eoc_ff   <= eoc_in;
      pass_ff  <= pass_in;
   end

endmodule

>>> src/sfr_fifo.sv
// Small command queue between front and back end.
`timescale 1ns / 1ps

module sfr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2,
   localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int NW   = $clog2(DEPTH + 1)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_valid,
   output logic             wr_ready,
   input  logic [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  logic             rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in;
   logic [PW-1:0]    rptr_ff, rptr_in;
   logic [NW-1:0]    count_ff, count_in;
   logic             push;
   logic             pop;

   assign wr_ready = (count_ff != NW'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_valid && rd_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (push) begin
         wptr_in = (wptr_ff == PW'(DEPTH - 1)) ? '0 : wptr_ff + PW'(1);
      end
      if (pop) begin
         rptr_in = (rptr_ff == PW'(DEPTH - 1)) ? '0 : rptr_ff + PW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + NW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= wr_data;
      end
   end

endmodule

>>> src/sfr_back.sv
// Back end: expands queued commands into response bytes, one per cycle while the receiver is ready.
`timescale 1ns / 1ps

module sfr_back #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8,
   localparam int LENW = $clog2(((PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX) + 1)
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   cmd_valid,
   output logic                                   cmd_ready,
   input  sfr_pkg::cmd_ctrl_type                  cmd_ctrl,
   input  logic [LENW-1:0]                        cmd_len,
   input  logic [PATTERN_MAX*sfr_pkg::BYTE_W-1:0] cmd_bytes,
   input  logic [REPLACE_MAX*sfr_pkg::BYTE_W-1:0] rep_vec,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic [sfr_pkg::BYTE_W-1:0]             rsp_out_byte,
   output logic                                   rsp_byte_valid,
   output logic                                   rsp_run_last,
   output logic                                   rsp_content_done
);

   logic                                   cur_valid_ff, cur_valid_in;
   sfr_pkg::cmd_ctrl_type                  cur_ctrl_ff, cur_ctrl_in;
   logic [LENW-1:0]                        rem_ff, rem_in;
   logic [PATTERN_MAX*sfr_pkg::BYTE_W-1:0] win_sh_ff, win_sh_in;
   logic [REPLACE_MAX*sfr_pkg::BYTE_W-1:0] rep_sh_ff, rep_sh_in;
   logic                                   out_valid_ff, out_valid_in;
   logic [sfr_pkg::BYTE_W-1:0]             out_byte_ff, out_byte_in;
   logic                                   out_bvalid_ff, out_bvalid_in;
   logic                                   out_last_ff, out_last_in;
   logic                                   out_done_ff, out_done_in;

   logic emit;
   logic last;

   assign emit      = cur_valid_ff && (!out_valid_ff || rsp_ready);
   assign last      = (rem_ff == LENW'(1));
   assign cmd_ready = !cur_valid_ff || (emit && last);

   always_comb begin
      cur_valid_in  = cur_valid_ff;
      cur_ctrl_in   = cur_ctrl_ff;
      rem_in        = rem_ff;
      win_sh_in     = win_sh_ff;
      rep_sh_in     = rep_sh_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_byte_in   = out_byte_ff;
      out_bvalid_in = out_bvalid_ff;
      out_last_in   = out_last_ff;
      out_done_in   = out_done_ff;
      if (emit) begin
         out_valid_in  = 1'b1;
         out_bvalid_in = 1'b1;
         out_last_in   = last;
         out_done_in   = last && cur_ctrl_ff.done;
         case (cur_ctrl_ff.kind)
            sfr_pkg::CMD_WIN:  out_byte_in = win_sh_ff[sfr_pkg::BYTE_W-1:0];
            sfr_pkg::CMD_REPL: out_byte_in = rep_sh_ff[sfr_pkg::BYTE_W-1:0];
            default: begin
               out_byte_in   = '0;
               out_bvalid_in = 1'b0;
            end
         endcase
         rem_in    = rem_ff - LENW'(1);
         win_sh_in = win_sh_ff >> sfr_pkg::BYTE_W;
         rep_sh_in = rep_sh_ff >> sfr_pkg::BYTE_W;
         if (last) begin
            cur_valid_in = 1'b0;
         end
      end
      if (cmd_valid && cmd_ready) begin
         cur_valid_in = 1'b1;
         cur_ctrl_in  = cmd_ctrl;
         rem_in       = cmd_len;
         win_sh_in    = cmd_bytes;
         rep_sh_in    = rep_vec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ctrl_ff   <= cur_ctrl_in;
      rem_ff        <= rem_in;
      win_sh_ff     <= win_sh_in;
      rep_sh_ff     <= rep_sh_in;
      out_byte_ff   <= out_byte_in;
      out_bvalid_ff <= out_bvalid_in;
      out_last_ff   <= out_last_in;
      out_done_ff   <= out_done_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_out_byte     = out_byte_ff;
   assign rsp_byte_valid   = out_bvalid_ff;
   assign rsp_run_last     = out_last_ff;
   assign rsp_content_done = out_done_ff;

endmodule

>>> src/stream_find_replace.sv
// Top level of the stream find/replace block: CSRs, front end, queue, back end.
`timescale 1ns / 1ps
//
// Byte-stream find and replace. One request carries one content byte; every
// leftmost, non-overlapping occurrence of the pattern is replaced by the
// replacement string. A request may cause zero to PATTERN_MAX or REPLACE_MAX
// responses; run_last flags the last response of a request, content_done the
// last one of the content (end_of_content). An empty pattern passes bytes through.
// CSRs: pattern_len, pattern_bytes, replace_len, replace_bytes, written via
// csr_we/csr_index/csr_wdata; the user is to write them while the block is idle,
// which the block does not enforce. Pattern writes are dropped while bytes of a
// partial match are held. Timing: the front end accepts a request, shifts out front
// bytes one at a time while the window is no pattern prefix (at most PATTERN_MAX),
// then queues a command if one is due; it takes no new request before that.
// Commands pass a two-entry queue; the back end emits one response per cycle while
// the receiver is ready, and a replacement of R bytes gives R responses.
// A stalled response receiver fills the queue and then holds off requests.
// Reset (synchronous) clears the CSRs to zero, empties the window and queue.
//
module stream_find_replace #(
   parameter int PATTERN_MAX = 8,
   parameter int REPLACE_MAX = 8
) (
   input  logic                               clock,
   input  logic                               reset,
   sfr_req_if.sink                            req,
   sfr_rsp_if.source                          rsp,
   input  logic                               csr_we,
   input  logic [sfr_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [sfr_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int CW   = $clog2(PATTERN_MAX + 1);
   localparam int LENW = $clog2(((PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX) + 1);
   localparam int PBW  = PATTERN_MAX * sfr_pkg::BYTE_W;
   localparam int RBW  = REPLACE_MAX * sfr_pkg::BYTE_W;
   localparam int QW   = $bits(sfr_pkg::cmd_ctrl_type) + LENW + PBW;

   logic [sfr_pkg::LEN_REG_W-1:0]  pat_len_ff;
   logic [sfr_pkg::CSR_DATA_W-1:0] pat_bytes_ff;
   logic [sfr_pkg::LEN_REG_W-1:0]  rep_len_ff;
   logic [sfr_pkg::CSR_DATA_W-1:0] rep_bytes_ff;

   logic [CW-1:0]         plen;
   logic [LENW-1:0]       rlen;
   logic [PBW-1:0]        pat_vec;
   logic [RBW-1:0]        rep_vec;
   logic                  held_empty;

   logic                  fq_valid, fq_ready;
   sfr_pkg::cmd_ctrl_type fq_ctrl;
   logic [LENW-1:0]       fq_len;
   logic [PBW-1:0]        fq_bytes;
   logic                  qb_valid, qb_ready;
   sfr_pkg::cmd_ctrl_type qb_ctrl;
   logic [LENW-1:0]       qb_len;
   logic [PBW-1:0]        qb_bytes;

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff   <= '0;
         pat_bytes_ff <= '0;
         rep_len_ff   <= '0;
         rep_bytes_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            sfr_pkg::CSR_PATTERN_LEN: begin
               if (held_empty) begin
                  pat_len_ff <= csr_wdata[sfr_pkg::LEN_REG_W-1:0];
               end
            end
            sfr_pkg::CSR_PATTERN_BYTES: begin
               if (held_empty) begin
                  pat_bytes_ff <= csr_wdata;
               end
            end
            sfr_pkg::CSR_REPLACE_LEN:   rep_len_ff   <= csr_wdata[sfr_pkg::LEN_REG_W-1:0];
            sfr_pkg::CSR_REPLACE_BYTES: rep_bytes_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // lengths saturate at the configured maxima
   assign plen = (32'(pat_len_ff) > PATTERN_MAX) ? CW'(PATTERN_MAX) : CW'(pat_len_ff);
   assign rlen = (32'(rep_len_ff) > REPLACE_MAX) ? LENW'(REPLACE_MAX) : LENW'(rep_len_ff);

   // bytes past the register width read as zero
   for (genvar i = 0; i < PATTERN_MAX; i++) begin : g_pat
      if (i < sfr_pkg::REG_BYTES) begin : g_in
         assign pat_vec[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] =
            pat_bytes_ff[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
      end else begin : g_zero
         assign pat_vec[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = '0;
      end
   end

   for (genvar i = 0; i < REPLACE_MAX; i++) begin : g_rep
      if (i < sfr_pkg::REG_BYTES) begin : g_in
         assign rep_vec[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] =
            rep_bytes_ff[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
      end else begin : g_zero
         assign rep_vec[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W] = '0;
      end
   end

   sfr_front #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_front (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req.valid),
      .req_ready          (req.ready),
      .req_data_byte      (req.data_byte),
      .req_end_of_content (req.end_of_content),
      .plen               (plen),
      .pat_vec            (pat_vec),
      .rlen               (rlen),
      .cmd_valid          (fq_valid),
      .cmd_ready          (fq_ready),
      .cmd_ctrl           (fq_ctrl),
      .cmd_len            (fq_len),
      .cmd_bytes          (fq_bytes),
      .held_empty         (held_empty)
   );

   sfr_fifo #(
      .WIDTH (QW),
      .DEPTH (2)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (fq_valid),
      .wr_ready (fq_ready),
      .wr_data  ({fq_ctrl, fq_len, fq_bytes}),
      .rd_valid (qb_valid),
      .rd_ready (qb_ready),
      .rd_data  ({qb_ctrl, qb_len, qb_bytes})
   );

   sfr_back #(
      .PATTERN_MAX (PATTERN_MAX),
      .REPLACE_MAX (REPLACE_MAX)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_valid        (qb_valid),
      .cmd_ready        (qb_ready),
      .cmd_ctrl         (qb_ctrl),
      .cmd_len          (qb_len),
      .cmd_bytes        (qb_bytes),
      .rep_vec          (rep_vec),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .rsp_out_byte     (rsp.out_byte),
      .rsp_byte_valid   (rsp.byte_valid),
      .rsp_run_last     (rsp.run_last),
      .rsp_content_done (rsp.content_done)
   );

endmodule

>>> src/sfr_checker.sv
// Port-level checks for the stream find/replace block, bound to the top level.
`timescale 1ns / 1ps

module sfr_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [sfr_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic                       rsp_byte_valid,
   input logic                       rsp_run_last,
   input logic                       rsp_content_done
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_byte_valid) &&
                                  $stable(rsp_run_last) && $stable(rsp_content_done))
      else $error("response payload changed while stalled");

   a_done_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_content_done |-> rsp_run_last)
      else $error("content end without end of request run");

   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_byte_valid |-> rsp_run_last && rsp_content_done &&
                                       (rsp_out_byte == '0))
      else $error("malformed empty end marker");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule

bind stream_find_replace sfr_checker u_sfr_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_out_byte     (rsp.out_byte),
   .rsp_byte_valid   (rsp.byte_valid),
   .rsp_run_last     (rsp.run_last),
   .rsp_content_done (rsp.content_done)
);

>>> sim/stream_find_replace_tb.sv
// Self-checking testbench for the stream find/replace block.
`timescale 1ns / 1ps

module stream_find_replace_tb;

   localparam int PAT_MAX       = 8;
   localparam int REP_MAX       = 8;
   localparam int SETTLE_CYCLES = 40;
   localparam int SETTINGS_N    = 12;

   typedef logic [sfr_pkg::BYTE_W-1:0]     byte_type;
   typedef logic [sfr_pkg::LEN_REG_W-1:0]  len_type;
   typedef logic [sfr_pkg::CSR_DATA_W-1:0] word_type;

   typedef struct packed {
      byte_type out_byte;
      logic     byte_valid;
      logic     run_last;
      logic     content_done;
   } rewrite_type;

   // Mirror of the block: registers, held window, expected output bytes.
   class rewrite_checker_type;
      len_type       pattern_len, replace_len;
      word_type      pattern_bytes, replace_bytes;
      byte_type      window [PAT_MAX];
      int unsigned   held;
      rewrite_type   rewritten_q[$];
      int unsigned   mismatches, requests, responses, contents, hits;

      function new();
         pattern_len   = '0;
         replace_len   = '0;
         pattern_bytes = '0;
         replace_bytes = '0;
         held          = 0;
         mismatches    = 0;
         requests      = 0;
         responses     = 0;
         contents      = 0;
         hits          = 0;
      endfunction

      function int unsigned pattern_used();
         return (pattern_len > PAT_MAX) ? PAT_MAX : pattern_len;
      endfunction

      function int unsigned replace_used();
         return (replace_len > REP_MAX) ? REP_MAX : replace_len;
      endfunction

      function byte_type pattern_at(int unsigned i);
         return pattern_bytes[sfr_pkg::BYTE_W*i +: sfr_pkg::BYTE_W];
      endfunction

      function bit window_is_prefix(int unsigned n);
         int unsigned i;
         for (i = 0; i < n; i++)
            if (window[i] != pattern_at(i))
               return 1'b0;
         return 1'b1;
      endfunction

      function rewrite_type byte_out(byte_type b);
         return '{out_byte: b, byte_valid: 1'b1, run_last: 1'b0, content_done: 1'b0};
      endfunction

      task report_mismatch(string msg);
         mismatches++;
         $display("[%0t] MISMATCH %s", $time, msg);
      endtask

      // pattern registers are frozen while a partial match is held
      function void write_reg(logic [sfr_pkg::CSR_IDX_W-1:0] index, word_type value);
         case (index)
            sfr_pkg::CSR_PATTERN_LEN:
               if (held == 0) pattern_len = value[sfr_pkg::LEN_REG_W-1:0];
            sfr_pkg::CSR_PATTERN_BYTES:
               if (held == 0) pattern_bytes = value;
            sfr_pkg::CSR_REPLACE_LEN:   replace_len = value[sfr_pkg::LEN_REG_W-1:0];
            sfr_pkg::CSR_REPLACE_BYTES: replace_bytes = value;
            default: ;
         endcase
      endfunction

      function void note_request(byte_type data_byte, logic eoc);
         rewrite_type fresh[$];
         rewrite_type item;
         int unsigned n, i;
         requests++;
         if (pattern_used() == 0) begin
            fresh.push_back(byte_out(data_byte));
         end else begin
            window[held] = data_byte;
            n = held + 1;
            if (n == pattern_used() && window_is_prefix(n)) begin
               for (i = 0; i < replace_used(); i++)
                  fresh.push_back(byte_out(
                     replace_bytes[sfr_pkg::BYTE_W*i +: sfr_pkg::BYTE_W]));
               hits++;
               n = 0;
            end else begin
               // slide the window until it is a pattern prefix again
               while (n > 0 && !window_is_prefix(n)) begin
                  fresh.push_back(byte_out(window[0]));
                  for (i = 0; i + 1 < n; i++)
                     window[i] = window[i + 1];
                  n--;
               end
            end
            held = n;
         end
         if (eoc) begin
            for (i = 0; i < held; i++)
               fresh.push_back(byte_out(window[i]));
            held = 0;
            if (fresh.size() == 0)
               fresh.push_back('{out_byte: '0, byte_valid: 1'b0, run_last: 1'b0,
                                 content_done: 1'b0});
            contents++;
         end
         if (fresh.size() > 0) begin
            item = fresh[fresh.size() - 1];
            item.run_last     = 1'b1;
            item.content_done = eoc;
            fresh[fresh.size() - 1] = item;
         end
         foreach (fresh[j])
            rewritten_q.push_back(fresh[j]);
      endfunction

      task check_output(rewrite_type got);
         rewrite_type want;
         responses++;
         if (rewritten_q.size() == 0) begin
            report_mismatch($sformatf("response with none expected: byte %02h valid %0b",
                                      got.out_byte, got.byte_valid));
            return;
         end
         want = rewritten_q.pop_front();
         if (got.out_byte != want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      got.out_byte, want.out_byte));
         if (got.byte_valid != want.byte_valid)
            report_mismatch($sformatf("byte_valid %0b, expected %0b",
                                      got.byte_valid, want.byte_valid));
         if (got.run_last != want.run_last)
            report_mismatch($sformatf("run_last %0b, expected %0b",
                                      got.run_last, want.run_last));
         if (got.content_done != want.content_done)
            report_mismatch($sformatf("content_done %0b, expected %0b",
                                      got.content_done, want.content_done));
      endtask
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             csr_we;
   logic [sfr_pkg::CSR_IDX_W-1:0]    csr_index;
   word_type                         csr_wdata;
   int                               sender_idle = 0;
   int                               receiver_stall = 0;
   rewrite_checker_type              rewriter;

   // per-setting pattern and replacement lengths, extremes and saturation included
   len_type plen_plan [SETTINGS_N] = '{4'd1, 4'd3, 4'd8, 4'd2, 4'd15, 4'd4,
                                       4'd0, 4'd6, 4'd8, 4'd2, 4'd5, 4'd7};
   len_type rlen_plan [SETTINGS_N] = '{4'd0, 4'd8, 4'd3, 4'd15, 4'd1, 4'd2,
                                       4'd8, 4'd0, 4'd5, 4'd4, 4'd6, 4'd1};
   int send_plan [4] = '{0, 77, 0, 29};
   int recv_plan [4] = '{0, 0, 77, 29};

   sfr_req_if req_ch ();
   sfr_rsp_if rsp_ch ();

   stream_find_replace #(
      .PATTERN_MAX (PAT_MAX),
      .REPLACE_MAX (REP_MAX)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // response side: check on handshake, then pick next ready
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         rewriter.check_output({rsp_ch.out_byte, rsp_ch.byte_valid, rsp_ch.run_last,
                                rsp_ch.content_done});
      rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall);
   end

   task automatic send_request(input byte_type data, input logic eoc);
      while ($urandom_range(0, 99) < sender_idle) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid          <= 1'b1;
      req_ch.data_byte      <= data;
      req_ch.end_of_content <= eoc;
      do @(posedge clock); while (!req_ch.ready);
      rewriter.note_request(data, eoc);
   endtask

   task automatic send_content(input byte_type text[$], input bit close);
      int i;
      for (i = 0; i < text.size(); i++)
         send_request(text[i], close && (i == text.size() - 1));
   endtask

   // drop valid, drain expected bytes, then let the front end settle
   task automatic wait_idle();
      req_ch.valid <= 1'b0;
      while (rewriter.rewritten_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [sfr_pkg::CSR_IDX_W-1:0] index,
                            input word_type value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      rewriter.write_reg(index, value);
   endtask

   // length registers get junk above bit 3; only the low nibble counts
   task automatic program_rewrite(input len_type plen,
                                  input word_type pbytes,
                                  input len_type rlen,
                                  input word_type rbytes);
      word_type len_word;
      len_word = {$urandom, $urandom};
      len_word[sfr_pkg::LEN_REG_W-1:0] = plen;
      csr_write(sfr_pkg::CSR_PATTERN_LEN, len_word);
      csr_write(sfr_pkg::CSR_PATTERN_BYTES, pbytes);
      len_word = {$urandom, $urandom};
      len_word[sfr_pkg::LEN_REG_W-1:0] = rlen;
      csr_write(sfr_pkg::CSR_REPLACE_LEN, len_word);
      csr_write(sfr_pkg::CSR_REPLACE_BYTES, rbytes);
      csr_we <= 1'b0;
   endtask

   // small alphabet so patterns overlap themselves, or full random bytes
   function automatic word_type random_pattern(bit wide);
      word_type pat;
      byte_type sym_a, sym_b;
      int       i;
      sym_a = byte_type'($urandom_range(0, 255));
      sym_b = byte_type'($urandom_range(0, 255));
      for (i = 0; i < sfr_pkg::REG_BYTES; i++) begin
         if (wide)
            pat[sfr_pkg::BYTE_W*i +: sfr_pkg::BYTE_W] = byte_type'($urandom_range(0, 255));
         else
            pat[sfr_pkg::BYTE_W*i +: sfr_pkg::BYTE_W] =
               ($urandom_range(0, 2) != 0) ? sym_a : sym_b;
      end
      return pat;
   endfunction

   // mostly whole or partial pattern runs, with stray and random bytes mixed in
   task automatic make_text(output byte_type text[$]);
      int unsigned target, plen, r, cut, i;
      text   = {};
      target = $urandom_range(1, 20);
      plen   = rewriter.pattern_used();
      while (text.size() < target) begin
         r = $urandom_range(0, 99);
         if (plen == 0 || r >= 85) begin
            text.push_back(byte_type'($urandom_range(0, 255)));
         end else if (r < 35) begin
            for (i = 0; i < plen; i++)
               text.push_back(rewriter.pattern_at(i));
         end else if (r < 60) begin
            cut = $urandom_range(1, plen);
            for (i = 0; i < cut; i++)
               text.push_back(rewriter.pattern_at(i));
         end else begin
            text.push_back(rewriter.pattern_at($urandom_range(0, plen - 1)));
         end
      end
   endtask

   initial begin
      byte_type text[$];
      int       phase, setting, k, sent;
      req_ch.valid          = 1'b0;
      req_ch.data_byte      = '0;
      req_ch.end_of_content = 1'b0;
      rsp_ch.ready          = 1'b0;
      csr_we                = 1'b0;
      csr_index             = '0;
      csr_wdata             = '0;
      rewriter = new();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: empty pattern, bytes pass through
      text = '{8'h00, 8'hFF};
      send_content(text, 1'b1);
      wait_idle();

      // "ab" -> "XYZ": match, mismatch slide, no-result request, flush on end
      program_rewrite(4'd2, 64'h6261, 4'd3, 64'h5A5958);
      text = '{8'h61, 8'h62, 8'h61, 8'h61, 8'h62, 8'h61, 8'h63};
      send_content(text, 1'b1);
      wait_idle();

      // saturated length, match deleted on the last byte: empty end marker
      program_rewrite(4'd15, '1, 4'd0, {$urandom, $urandom});
      text = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
      send_content(text, 1'b1);
      wait_idle();

      // pattern writes while a byte is held are dropped; replacement still lands
      send_request(8'hFF, 1'b0);
      wait_idle();
      program_rewrite(4'd1, '0, 4'd15, {$urandom, $urandom});
      text = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00};
      send_content(text, 1'b1);
      wait_idle();

      for (phase = 0; phase < 4; phase++) begin
         sender_idle    = send_plan[phase];
         receiver_stall = recv_plan[phase];
         for (setting = 0; setting < 3; setting++) begin
            k = phase * 3 + setting;
            program_rewrite(plen_plan[k], random_pattern(k % 4 == 3), rlen_plan[k],
                            {$urandom, $urandom});
            sent = 0;
            while (sent < 30) begin
               make_text(text);
               send_content(text, 1'b1);
               sent += text.size();
            end
            wait_idle();
         end
      end

      $display("Covered %0d requests in %0d contents over %0d register settings",
               rewriter.requests, rewriter.contents, SETTINGS_N + 4);
      $display("and 4 flow phases: %0d responses checked, %0d pattern hits, %0d mismatches",
               rewriter.responses, rewriter.hits, rewriter.mismatches);
      if (rewriter.mismatches == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d responses still expected", rewriter.rewritten_q.size());
      $display("Verification failed");
      $finish;
   end

endmodule

>>> filelist.f
src/sfr_pkg.sv
src/sfr_if.sv
src/sfr_front.sv
src/sfr_fifo.sv
src/sfr_back.sv
src/stream_find_replace.sv
src/sfr_checker.sv
sim/stream_find_replace_tb.sv
